/* hw/rtl/spq_pkg.sv */
// Shared constants and types for the sorted priority queue.
package spq_pkg;

  localparam int unsigned CapacityDef = 16;
  localparam int unsigned TagW        = 32;
  localparam int unsigned PrioW       = 16;
  localparam int unsigned OccW        = 5;

  typedef enum logic {
    KIND_INSERT = 1'b0,
    KIND_REMOVE = 1'b1
  } kind_e;

  // Per-cycle command that is broadcast to every cell in the chain.
  typedef struct packed {
    logic             ins;
    logic             rem;
    logic [TagW-1:0]  tag;
    logic [PrioW-1:0] prio;
  } spq_ctrl_t;

endpackage

/* hw/rtl/spq_cell.sv */
// One slot of the sorted chain: holds an entry and trades it with its neighbors.
module spq_cell (
  input  logic                       clk_i,
  input  spq_pkg::spq_ctrl_t         ctrl_i,
  input  logic                       live_i,
  input  logic                       left_keep_i,
  input  logic [spq_pkg::TagW-1:0]   left_tag_i,
  input  logic [spq_pkg::PrioW-1:0]  left_prio_i,
  input  logic [spq_pkg::TagW-1:0]   right_tag_i,
  input  logic [spq_pkg::PrioW-1:0]  right_prio_i,
  output logic                       keep_o,
  output logic [spq_pkg::TagW-1:0]   tag_o,
  output logic [spq_pkg::PrioW-1:0]  prio_o
);

  logic [spq_pkg::TagW-1:0]  tag_q, tag_d;
  logic [spq_pkg::PrioW-1:0] prio_q, prio_d;

  // A live entry of greater or equal priority stays ahead of the new one.
  assign keep_o = live_i && (prio_q >= ctrl_i.prio);

  always_comb begin
    tag_d  = tag_q;
    prio_d = prio_q;
    priority if (ctrl_i.rem) begin
      tag_d  = right_tag_i;
      prio_d = right_prio_i;
    end else if (ctrl_i.ins && !keep_o) begin
      if (left_keep_i) begin
        tag_d  = ctrl_i.tag;
        prio_d = ctrl_i.prio;
      end else begin
        tag_d  = left_tag_i;
        prio_d = left_prio_i;
      end
    end else begin
      tag_d  = tag_q;
      prio_d = prio_q;
    end
  end

  always_ff @(posedge clk_i) begin
    tag_q  <= tag_d;
    prio_q <= prio_d;
  end

  assign tag_o  = tag_q;
  assign prio_o = prio_q;

endmodule

/* hw/rtl/sorted_priority_queue_top.sv */
// Top level of the sorted priority queue built as a chain of entry cells.
// The result of a command appears with done_o in the cycle after the transfer.
// Throughput: one command per cycle; busy never rises, so start may stay high.
// Every cell compares the new priority at once and shifts in that same cycle.
// Reset clears the live count, the result strobe and the error flags; cell contents stay undefined.
// The receiver cannot stall, so each result is shown for exactly one cycle.
module sorted_priority_queue_top #(
  parameter int unsigned Capacity = spq_pkg::CapacityDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic                       kind_i,
  input  logic [spq_pkg::TagW-1:0]   new_tag_i,
  input  logic [spq_pkg::PrioW-1:0]  new_priority_i,
  output logic                       done_o,
  output logic [spq_pkg::TagW-1:0]   head_tag_o,
  output logic [spq_pkg::PrioW-1:0]  head_priority_o,
  output logic                       head_valid_o,
  output logic [spq_pkg::OccW-1:0]   occupancy_o,
  output logic                       is_full_flag_o,
  output logic                       rejected_o,
  output logic                       nothing_removed_o
);

  localparam int unsigned CntW = $clog2(Capacity + 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Capacity);

  logic [CntW-1:0] count_q, count_d;
  logic            done_q;
  logic            rejected_q, rejected_d;
  logic            empty_rm_q, empty_rm_d;
  logic            is_full, queue_empty, accept;

  spq_pkg::spq_ctrl_t ctrl;

  logic [Capacity-1:0]        keep;
  logic [Capacity-1:0]        live;
  logic [spq_pkg::TagW-1:0]   cell_tag  [Capacity];
  logic [spq_pkg::PrioW-1:0]  cell_prio [Capacity];
  logic [31:0]                count_ext;

  assign busy        = 1'b0;
  assign accept      = start && !busy;
  assign is_full     = (count_q == CntFull);
  assign queue_empty = (count_q == '0);

  always_comb begin
    ctrl.ins   = accept && (spq_pkg::kind_e'(kind_i) == spq_pkg::KIND_INSERT) && !is_full;
    ctrl.rem   = accept && (spq_pkg::kind_e'(kind_i) == spq_pkg::KIND_REMOVE) && !queue_empty;
    ctrl.tag   = new_tag_i;
    ctrl.prio  = new_priority_i;
    rejected_d = accept && (spq_pkg::kind_e'(kind_i) == spq_pkg::KIND_INSERT) && is_full;
    empty_rm_d = accept && (spq_pkg::kind_e'(kind_i) == spq_pkg::KIND_REMOVE) && queue_empty;
    count_d    = count_q;
    priority if (ctrl.ins) begin
      count_d = count_q + CntW'(1);
    end else if (ctrl.rem) begin
      count_d = count_q - CntW'(1);
    end else begin
      count_d = count_q;
    end
  end

  for (genvar i = 0; i < Capacity; i++) begin : g_cell
    logic                      left_keep;
    logic [spq_pkg::TagW-1:0]  left_tag, right_tag;
    logic [spq_pkg::PrioW-1:0] left_prio, right_prio;

    assign live[i] = (CntW'(i) < count_q);

    if (i == 0) begin : g_first
      assign left_keep = 1'b1;
      assign left_tag  = new_tag_i;
      assign left_prio = new_priority_i;
    end else begin : g_inner
      assign left_keep = keep[i-1];
      assign left_tag  = cell_tag[i-1];
      assign left_prio = cell_prio[i-1];
    end

    if (i == Capacity - 1) begin : g_last
      assign right_tag  = cell_tag[i];
      assign right_prio = cell_prio[i];
    end else begin : g_body
      assign right_tag  = cell_tag[i+1];
      assign right_prio = cell_prio[i+1];
    end

    spq_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .live_i       (live[i]),
      .left_keep_i  (left_keep),
      .left_tag_i   (left_tag),
      .left_prio_i  (left_prio),
      .right_tag_i  (right_tag),
      .right_prio_i (right_prio),
      .keep_o       (keep[i]),
      .tag_o        (cell_tag[i]),
      .prio_o       (cell_prio[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      done_q     <= 1'b0;
      rejected_q <= 1'b0;
      empty_rm_q <= 1'b0;
    end else begin
      count_q    <= count_d;
      done_q     <= accept;
      rejected_q <= rejected_d;
      empty_rm_q <= empty_rm_d;
    end
  end

  assign count_ext         = 32'(count_q);
  assign done_o            = done_q;
  assign head_valid_o      = !queue_empty;
  assign head_tag_o        = queue_empty ? '0 : cell_tag[0];
  assign head_priority_o   = queue_empty ? '0 : cell_prio[0];
  assign occupancy_o       = count_ext[spq_pkg::OccW-1:0];
  assign is_full_flag_o    = is_full;
  assign rejected_o        = rejected_q;
  assign nothing_removed_o = empty_rm_q;

  // Kept cells always form a prefix of the chain, since entries stay sorted.
  a_keep_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((keep >> 1) & ~keep) == '0)
    else $error("keep flags do not form a prefix");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntFull)
    else $error("live count exceeds capacity");

  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> done_o)
    else $error("missing result after transfer");

  a_reject_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rejected_o |-> (is_full && $stable(count_q)))
    else $error("rejected insert changed the queue");

  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(rejected_o && nothing_removed_o))
    else $error("both error flags set");

endmodule
